>>> rtl/core/iirl_pkg.sv
// Shared types, constants and codes for the indexed insert/remove list.
`timescale 1ns / 1ps

package iirl_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_BITS  = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = 7;
   localparam int POS_BITS   = 7;
   localparam int CAP_BITS   = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT    = COUNT_BITS'(DEPTH);
   localparam logic [CAP_BITS-1:0]   CAPACITY_RESET = CAP_BITS'(64);

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   // register index, taken from byte address bit 2
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [1:0]           operation;
      logic [POS_BITS-1:0]  position;
      logic [WORD_BITS-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [WORD_BITS-1:0]  word_out;
      logic [COUNT_BITS-1:0] count;
      logic                  is_full;
      logic                  is_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_DRAIN,
      S_PLACE,
      S_READ,
      S_FETCH,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PLAN_DONE,
      PLAN_PLACE,
      PLAN_SHIFT,
      PLAN_READ
   } plan_type;

   typedef struct packed {
      logic accept;
      logic move;
      logic place;
      logic read;
      logic capture;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      plan_type plan;
      logic     last_move;
      logic     place_after;
      logic     out_free;
   } dp_status_type;

endpackage

>>> rtl/core/iirl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iirl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/iirl_ctrl.sv
// Sequencer for the list: accept, shift moves, placement, read and result hand-off.
`timescale 1ns / 1ps

module iirl_ctrl import iirl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      dp_cmd    = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.accept = 1'b1;
               case (dp_status.plan)
                  PLAN_PLACE: state_in = S_PLACE;
                  PLAN_SHIFT: state_in = S_MOVE;
                  PLAN_READ:  state_in = S_READ;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_MOVE: begin
            dp_cmd.move = 1'b1;
            if (dp_status.last_move) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last moved entry is written this cycle
            state_in = dp_status.place_after ? S_PLACE : S_FINISH;
         end
         S_PLACE: begin
            dp_cmd.place = 1'b1;
            state_in     = S_FINISH;
         end
         S_READ: begin
            dp_cmd.read = 1'b1;
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            dp_cmd.capture = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (dp_status.out_free) begin
               dp_cmd.publish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/iirl_datapath.sv
// List datapath: checks, count, entry RAM with shift pointers, result registers.
`timescale 1ns / 1ps

module iirl_datapath import iirl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   input  logic [CAP_BITS-1:0] capacity,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_payload
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  up_ff, up_in;
   logic [ADDR_BITS-1:0]  pos_ff, pos_in;
   logic [WORD_BITS-1:0]  word_ff, word_in;
   logic [ADDR_BITS-1:0]  src_ff, src_in;
   logic [ADDR_BITS-1:0]  end_ff, end_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_BITS-1:0]  pend_dst_ff, pend_dst_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CAP_BITS-1:0]   cap_eff;
   logic [1:0]            dec_status;
   logic [COUNT_BITS-1:0] dec_count;
   plan_type              dec_plan;
   logic [COUNT_BITS-1:0] count_less;
   logic [POS_BITS-1:0]   pos_more;
   logic [ADDR_BITS-1:0]  src_start;
   logic [ADDR_BITS-1:0]  src_end;

   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [WORD_BITS-1:0]  ram_rd_data;

   assign cap_eff    = (capacity > DEPTH_COUNT) ? DEPTH_COUNT : capacity;
   assign count_less = count_ff - COUNT_BITS'(1);
   assign pos_more   = req_payload.position + POS_BITS'(1);

   // check the request against the current count
   always_comb begin
      dec_status = STATUS_INVALID;
      dec_count  = count_ff;
      dec_plan   = PLAN_DONE;
      src_start  = count_less[ADDR_BITS-1:0];
      src_end    = req_payload.position[ADDR_BITS-1:0];
      case (req_payload.operation)
         OP_INSERT: begin
            if (req_payload.position > count_ff) begin
               dec_status = STATUS_INVALID;
            end else if (count_ff >= cap_eff) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_status = STATUS_OK;
               dec_count  = count_ff + COUNT_BITS'(1);
               dec_plan   = (req_payload.position == count_ff) ? PLAN_PLACE : PLAN_SHIFT;
            end
         end
         OP_REMOVE: begin
            src_start = pos_more[ADDR_BITS-1:0];
            src_end   = count_less[ADDR_BITS-1:0];
            if (count_ff == '0) begin
               dec_status = STATUS_EMPTY;
            end else if (req_payload.position >= count_ff) begin
               dec_status = STATUS_INVALID;
            end else begin
               dec_status = STATUS_OK;
               dec_count  = count_less;
               dec_plan   = (req_payload.position == count_less) ? PLAN_DONE : PLAN_SHIFT;
            end
         end
         OP_READ: begin
            if (req_payload.position >= count_ff) begin
               dec_status = STATUS_INVALID;
            end else begin
               dec_status = STATUS_OK;
               dec_plan   = PLAN_READ;
            end
         end
         default: begin
            dec_status = STATUS_INVALID;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      up_in        = up_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      src_in       = src_ff;
      end_in       = end_ff;
      pend_in      = dp_cmd.move;
      pend_dst_in  = pend_dst_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (dp_cmd.accept) begin
         count_in        = dec_count;
         up_in           = (req_payload.operation == OP_INSERT);
         pos_in          = req_payload.position[ADDR_BITS-1:0];
         word_in         = req_payload.word_in;
         src_in          = src_start;
         end_in          = src_end;
         res_in.status   = dec_status;
         res_in.word_out = '0;
         res_in.count    = dec_count;
         res_in.is_full  = (dec_count >= cap_eff);
         res_in.is_empty = (dec_count == '0);
      end
      if (dp_cmd.move) begin
         src_in      = up_ff ? (src_ff - ADDR_BITS'(1)) : (src_ff + ADDR_BITS'(1));
         pend_dst_in = up_ff ? (src_ff + ADDR_BITS'(1)) : (src_ff - ADDR_BITS'(1));
      end
      if (dp_cmd.capture) begin
         res_in.word_out = ram_rd_data;
      end
      if (dp_cmd.publish) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      up_ff       <= up_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      src_ff      <= src_in;
      end_ff      <= end_in;
      pend_dst_ff <= pend_dst_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // a read issued on one cycle is written one place over on the next
   assign ram_rd_en   = dp_cmd.move | dp_cmd.read;
   assign ram_rd_addr = dp_cmd.move ? src_ff : pos_ff;
   assign ram_wr_en   = pend_ff | dp_cmd.place;
   assign ram_wr_addr = pend_ff ? pend_dst_ff : pos_ff;
   assign ram_wr_data = pend_ff ? ram_rd_data : word_ff;

   iirl_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign dp_status.plan        = dec_plan;
   assign dp_status.last_move   = (src_ff == end_ff);
   assign dp_status.place_after = up_ff;
   assign dp_status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accept && (req_payload.operation == OP_INSERT) && (dec_status == STATUS_OK)
      |=> count_ff == $past(count_ff) + COUNT_BITS'(1))
      else $error("successful insert did not raise the count");

   a_write_clash: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !dp_cmd.place)
      else $error("shift write and placement write in the same cycle");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.publish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still held");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_OK) |-> rsp_ff.word_out == '0)
      else $error("failed request carries a data word");
`endif

endmodule

>>> rtl/core/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list: register port, sequencer and datapath.
`timescale 1ns / 1ps

// Ordered list of up to 64 words. Each request inserts a word at an index
// (later entries move up), removes the entry at an index (later entries move
// down) or reads the entry at an index; each request yields one response with
// status, read word, count after the request and full/empty flags.
// Channels: req_* takes requests, rsp_* delivers responses; a transfer happens
// when valid is high and stall is low. The csr_* port writes the capacity
// register at byte address 0 (pready always high).
// Flow: one request at a time; req_stall is low only while the block waits
// for a request. After accept, a middle insert moves later entries up, then
// places the word; an end insert places it at once; a remove moves later ones
// down (none for the last entry); a read reads the RAM, then captures the word;
// a rejected request goes straight to the hand-off to the output register.
// Entries live in one RAM with one read and one write port, so a shift moves
// one entry per cycle.
// A waiting response does not block: the next request is accepted and worked
// on while rsp_stall is high, and only its hand-off waits for the output
// register. Reset empties the list and sets capacity to 64; stored words are
// not cleared.
module indexed_insert_remove_list import iirl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [CAP_BITS-1:0] capacity_ff, capacity_in;
   logic [0:0]          csr_index;
   logic                csr_write;
   dp_cmd_type          dp_cmd;
   dp_status_type       dp_status;

   // register decode: one register per 32-bit word
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_index == REG_CAPACITY)) begin
         capacity_in = csr_pwdata[CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = (csr_index == REG_CAPACITY) ?
                       {{(CSR_DATA_BITS-CAP_BITS){1'b0}}, capacity_ff} : '0;

   iirl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   iirl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .capacity    (capacity_ff),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the indexed insert/remove list.
`timescale 1ns / 1ps

module tb_top;
   import iirl_pkg::*;

   // Operation code that the block defines no action for.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int TOTAL_REQS = 1750;

   // Which way the random mix pushes the list length during a phase.
   typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_payload;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   indexed_insert_remove_list dut (.*);

   always #4 clock = ~clock;

   // Requests waiting to be driven, and responses the list model has computed
   // but the block has not yet delivered.
   req_type queued_reqs[$];
   rsp_type awaited_rsps[$];

   // List model: stored words, current length and capacity register.
   logic [WORD_BITS-1:0] list_words [DEPTH];
   int                   held_count = 0;
   logic [CAP_BITS-1:0]  capacity_reg = CAPACITY_RESET;

   // Length the stimulus generator expects when the next queued request runs;
   // it steers positions toward the interesting range.
   int  planned_count = 0;
   bit  pacing_on = 1'b1;   // random gaps and stalls on/off for the phase
   int  mismatches = 0;
   int  rsp_seen = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;

   function automatic int effective_cap();
      return (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("tb_top: response %0d %s got %h want %h", rsp_seen, what, got, want);
   endtask

   // Apply one accepted request to the list model and queue its response.
   task automatic predict_list_response(input req_type r);
      rsp_type e;
      int      cap;
      int      p;
      e = '0;
      cap = effective_cap();
      p = int'(r.position);
      e.status = STATUS_INVALID;
      case (r.operation)
         OP_INSERT: begin
            if (p > held_count)
               e.status = STATUS_INVALID;
            else if (held_count >= cap || held_count >= DEPTH)
               e.status = STATUS_FULL;
            else begin
               for (int i = held_count; i > p; i--)
                  list_words[i] = list_words[i-1];
               list_words[p] = r.word_in;
               held_count++;
               e.status = STATUS_OK;
            end
         end
         OP_REMOVE: begin
            if (held_count == 0)
               e.status = STATUS_EMPTY;
            else if (p >= held_count)
               e.status = STATUS_INVALID;
            else begin
               for (int i = p; i + 1 < held_count; i++)
                  list_words[i] = list_words[i+1];
               held_count--;
               e.status = STATUS_OK;
            end
         end
         OP_READ: begin
            if (p < held_count) begin
               e.word_out = list_words[p];
               e.status = STATUS_OK;
            end
         end
         default: ;   // unused code: nothing changes, invalid argument
      endcase
      e.count = COUNT_BITS'(held_count);
      e.is_full = (held_count >= cap);
      e.is_empty = (held_count == 0);
      awaited_rsps.push_back(e);
   endtask

   // Queue a request and track the length it should leave behind.
   task automatic queue_req(input logic [1:0] op, input int pos,
                            input logic [WORD_BITS-1:0] word);
      req_type r;
      int      cap;
      r.operation = op;
      r.position = POS_BITS'(pos);
      r.word_in = word;
      cap = effective_cap();
      if (op == OP_INSERT && pos <= planned_count && planned_count < cap)
         planned_count++;
      else if (op == OP_REMOVE && planned_count > 0 && pos < planned_count)
         planned_count--;
      queued_reqs.push_back(r);
   endtask

   // Mostly well-formed requests at in-range positions, a little noise.
   task automatic queue_random_req(input lean_type lean);
      int pick;
      int ins_top;
      int rem_top;
      pick = $urandom_range(0, 99);
      ins_top = (lean == LEAN_FILL) ? 55 : (lean == LEAN_DRAIN) ? 20 : 38;
      rem_top = ins_top + ((lean == LEAN_DRAIN) ? 55 : (lean == LEAN_FILL) ? 20 : 37);
      if (pick < ins_top)
         queue_req(OP_INSERT, $urandom_range(0, planned_count), $urandom);
      else if (pick < rem_top)
         queue_req(OP_REMOVE, (planned_count > 0) ? $urandom_range(0, planned_count - 1) : 0,
                   $urandom);
      else if (pick < 95)
         queue_req(OP_READ, (planned_count > 0) ? $urandom_range(0, planned_count - 1) : 0,
                   $urandom);
      else
         queue_req(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
   endtask

   // Block is idle once nothing is queued, in flight or awaited.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0);
   endtask

   // Register write (setup + access), then read back through the same port.
   task automatic csr_write_capacity(input logic [CAP_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {REG_CAPACITY, 2'b00};
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      capacity_reg = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(value))
         report_mismatch("capacity readback", 64'(csr_prdata), 64'(value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Request driver: on acceptance the model is advanced; a fresh request is
   // presented after a per-request gap. Payload holds while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_list_response(req_payload);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (queued_reqs.size() > 0) begin
               req_payload <= queued_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap = pacing_on ? $urandom_range(0, 4) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each delivered response is checked field by field
   // against the oldest awaited one; stall is drawn per response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (awaited_rsps.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_payload), '0);
            end else begin
               rsp_type want;
               want = awaited_rsps.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", 64'(rsp_payload.status), 64'(want.status));
               if (rsp_payload.word_out !== want.word_out)
                  report_mismatch("word_out", 64'(rsp_payload.word_out),
                                  64'(want.word_out));
               if (rsp_payload.count !== want.count)
                  report_mismatch("count", 64'(rsp_payload.count), 64'(want.count));
               if (rsp_payload.is_full !== want.is_full)
                  report_mismatch("is_full", 64'(rsp_payload.is_full), 64'(want.is_full));
               if (rsp_payload.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 64'(rsp_payload.is_empty),
                                  64'(want.is_empty));
            end
            rsp_hold = pacing_on ? $urandom_range(0, 4) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // Watchdog: far above the slowest legal run (every request shifting a
   // full list with maximum gaps and stalls).
   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      lean_type fixed_lean [6];
      int       fixed_caps [6];
      int       fixed_items [6];
      int       total;
      fixed_caps  = '{1, 0, 127, 3, 64, 2};
      fixed_items = '{120, 60, 350, 200, 300, 100};
      fixed_lean  = '{LEAN_EVEN, LEAN_EVEN, LEAN_FILL, LEAN_DRAIN, LEAN_EVEN, LEAN_EVEN};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, inserts at front/end/middle, reads at
      // every live slot and past the end, remove errors, unused code,
      // removes at middle/last/front, out-of-range inserts.
      queue_req(OP_READ, 0, '0);
      queue_req(OP_REMOVE, 0, '0);
      queue_req(OP_INSERT, 1, 32'h1234_5678);
      queue_req(OP_INSERT, 0, 32'h0000_0000);
      queue_req(OP_INSERT, 0, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 2, 32'hA5A5_A5A5);
      queue_req(OP_INSERT, 1, 32'h5A5A_5A5A);
      for (int i = 0; i < 4; i++)
         queue_req(OP_READ, i, '1);
      queue_req(OP_READ, 4, '0);
      queue_req(OP_READ, 127, '0);
      queue_req(OP_REMOVE, 127, '0);
      queue_req(OP_REMOVE, 4, '0);
      queue_req(OP_UNUSED, 0, '1);
      queue_req(OP_REMOVE, 1, '0);
      queue_req(OP_REMOVE, 2, '0);
      queue_req(OP_REMOVE, 0, '0);
      queue_req(OP_READ, 0, '0);
      queue_req(OP_INSERT, 64, 32'hDEAD_BEEF);
      queue_req(OP_INSERT, 127, 32'hDEAD_BEEF);
      total = queued_reqs.size();
      wait_drained();

      // Capacity sweep: tiny, zero, above the depth (fill to the top),
      // lowered below the live length (drain), reset value, tiny again, then random.
      for (int ph = 0; total < TOTAL_REQS; ph++) begin
         int       cap;
         int       items;
         lean_type lean;
         if (ph < 6) begin
            cap = fixed_caps[ph];
            items = fixed_items[ph];
            lean = fixed_lean[ph];
         end else begin
            cap = $urandom_range(0, 127);
            items = 100;
            lean = lean_type'($urandom_range(0, 2));
         end
         csr_write_capacity(CAP_BITS'(cap));
         pacing_on = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < items; k++)
            queue_random_req(lean);
         total += items;
         wait_drained();
      end

      // Let any trailing activity show up before the verdict.
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/iirl_pkg.sv
rtl/core/iirl_ram.sv
rtl/core/iirl_ctrl.sv
rtl/core/iirl_datapath.sv
rtl/core/indexed_insert_remove_list.sv
bench/tb_top.sv
